[src/tflc_pkg.sv]
package tflc_pkg;

  localparam logic [3:0] COOLDOWN_TICKS = 4'd4;

  localparam logic signed [4:0] LVL_MAX = 5'sd10;
  localparam logic signed [4:0] LVL_MIN = -5'sd3;

  typedef enum logic [2:0] {
    REG_BATT_UP_TWO   = 3'd0,
    REG_BATT_UP_ONE   = 3'd1,
    REG_BATT_DOWN_ONE = 3'd2,
    REG_BATT_DOWN_TWO = 3'd3,
    REG_CPU_ALARM_ONE = 3'd4,
    REG_CPU_ALARM_TWO = 3'd5,
    REG_CPU_ALARM_THR = 3'd6,
    REG_CPU_CLEAR     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [9:0]  battery_up_two;
    logic [9:0]  battery_up_one;
    logic [9:0]  battery_down_one;
    logic [9:0]  battery_down_two;
    logic [10:0] cpu_alarm_one;
    logic [10:0] cpu_alarm_two;
    logic [10:0] cpu_alarm_three;
    logic [10:0] cpu_clear;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    battery_up_two:   10'd350,
    battery_up_one:   10'd345,
    battery_down_one: 10'd335,
    battery_down_two: 10'd330,
    cpu_alarm_one:    11'd650,
    cpu_alarm_two:    11'd750,
    cpu_alarm_three:  11'd850,
    cpu_clear:        11'd550
  };

  typedef struct packed {
    logic signed [10:0] battery_temp;
    logic               battery_valid;
    logic [10:0]        cpu_temp;
    logic               cpu_valid;
  } sample_t;

  typedef struct packed {
    logic signed [4:0] chosen_level;
    logic [1:0]        alarm_level;
  } level_t;

  typedef struct packed {
    logic       run_mode;
    logic [4:0] target_celsius;
    logic [6:0] fan_percent;
    logic [6:0] cooler_percent;
  } drive_t;

  // Fan percent is rpm/60 truncated; rpm = 6000 - (6 - level)*400 below level six.
  function automatic drive_t level_drive(input logic signed [4:0] lvl);
    drive_t d;
    d.run_mode       = 1'b0;
    d.target_celsius = 5'd10;
    d.fan_percent    = 7'd100;
    d.cooler_percent = 7'd100;
    case (lvl)
      -5'sd3:  d = '{1'b1, 5'd20, 7'd40, 7'd20};
      -5'sd2:  d = '{1'b1, 5'd20, 7'd46, 7'd35};
      -5'sd1:  d = '{1'b1, 5'd20, 7'd53, 7'd60};
      5'sd0:   d = '{1'b0, 5'd20, 7'd60, 7'd100};
      5'sd1:   d = '{1'b0, 5'd19, 7'd66, 7'd100};
      5'sd2:   d = '{1'b0, 5'd18, 7'd73, 7'd100};
      5'sd3:   d = '{1'b0, 5'd17, 7'd80, 7'd100};
      5'sd4:   d = '{1'b0, 5'd16, 7'd86, 7'd100};
      5'sd5:   d = '{1'b0, 5'd15, 7'd93, 7'd100};
      5'sd6:   d = '{1'b0, 5'd14, 7'd100, 7'd100};
      5'sd7:   d = '{1'b0, 5'd13, 7'd100, 7'd100};
      5'sd8:   d = '{1'b0, 5'd12, 7'd100, 7'd100};
      5'sd9:   d = '{1'b0, 5'd11, 7'd100, 7'd100};
      default: d = '{1'b0, 5'd10, 7'd100, 7'd100};
    endcase
    return d;
  endfunction

endpackage

[src/tflc_if.sv]
interface tflc_in_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] battery_temp;
  logic               battery_valid;
  logic [10:0]        cpu_temp;
  logic               cpu_valid;

  modport source (output valid, battery_temp, battery_valid, cpu_temp, cpu_valid,
                  input ready);
  modport sink (input valid, battery_temp, battery_valid, cpu_temp, cpu_valid,
                output ready);
endinterface

interface tflc_out_if;
  logic              valid;
  logic              ready;
  logic signed [4:0] chosen_level;
  logic              run_mode;
  logic [4:0]        target_celsius;
  logic [6:0]        fan_percent;
  logic [6:0]        cooler_percent;
  logic [1:0]        alarm_level;

  modport source (output valid, chosen_level, run_mode, target_celsius, fan_percent,
                  cooler_percent, alarm_level, input ready);
  modport sink (input valid, chosen_level, run_mode, target_celsius, fan_percent,
                cooler_percent, alarm_level, output ready);
endinterface

interface tflc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [10:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/tflc_cfg_regs.sv]
module tflc_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  tflc_cfg_if.sink      cfg,
  output tflc_pkg::cfg_t regs
);
  import tflc_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= CFG_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_BATT_UP_TWO:   regs.battery_up_two   <= cfg.data[9:0];
        REG_BATT_UP_ONE:   regs.battery_up_one   <= cfg.data[9:0];
        REG_BATT_DOWN_ONE: regs.battery_down_one <= cfg.data[9:0];
        REG_BATT_DOWN_TWO: regs.battery_down_two <= cfg.data[9:0];
        REG_CPU_ALARM_ONE: regs.cpu_alarm_one    <= cfg.data;
        REG_CPU_ALARM_TWO: regs.cpu_alarm_two    <= cfg.data;
        REG_CPU_ALARM_THR: regs.cpu_alarm_three  <= cfg.data;
        REG_CPU_CLEAR:     regs.cpu_clear        <= cfg.data;
        default:           regs <= regs;
      endcase
    end
  end

endmodule

[src/tflc_ctrl.sv]
module tflc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  tflc_pkg::sample_t smp,
  input  tflc_pkg::cfg_t    regs,
  output tflc_pkg::level_t  result
);
  import tflc_pkg::*;

  logic signed [4:0] base_level;
  logic              level_loaded;
  logic [1:0]        emergency;
  logic [10:0]       cpu_filtered;
  logic              filter_primed;
  logic [3:0]        hold_ticks;

  logic signed [4:0] base0, base1, base_next;
  logic [1:0]        emer_next, nl;
  logic [10:0]       filt_next;
  logic              primed_next;
  logic [3:0]        hold1, hold_next;
  logic [12:0]       filt_mix;
  logic signed [11:0] batt_x;
  logic signed [2:0] delta;
  logic signed [5:0] stepped;
  logic signed [4:0] fmin;

  // (batt - 350) / 10 toward zero, clamped to the level range
  function automatic logic signed [4:0] first_level(input logic signed [10:0] batt);
    logic signed [11:0] d;
    logic [6:0]         mag;
    logic [14:0]        prod;
    logic [3:0]         q;
    d    = $signed({batt[10], batt}) - 12'sd350;
    mag  = d[11] ? 7'(-d) : 7'(d);
    prod = 15'(mag) * 15'd205;
    q    = prod[14:11];
    if (batt >= 11'sd450) return LVL_MAX;
    else if (batt <= 11'sd320) return LVL_MIN;
    else if (d[11]) return -$signed({1'b0, q});
    else return $signed({1'b0, q});
  endfunction

  function automatic logic signed [4:0] clamp_level(input logic signed [5:0] v);
    if (v > 6'sd10) return LVL_MAX;
    else if (v < -6'sd3) return LVL_MIN;
    else return 5'(v);
  endfunction

  // quarter-weight low-pass: (cpu*25 + filt*75)/100 == (cpu + 3*filt) >> 2
  assign filt_mix = {2'b00, smp.cpu_temp} + {2'b00, cpu_filtered}
                  + {1'b0, cpu_filtered, 1'b0};
  assign batt_x = $signed({smp.battery_temp[10], smp.battery_temp});

  always_comb begin
    if (level_loaded) base0 = base_level;
    else if (smp.battery_valid) base0 = first_level(smp.battery_temp);
    else base0 = '0;

    filt_next   = cpu_filtered;
    primed_next = filter_primed;
    emer_next   = emergency;
    base1       = base0;
    hold1       = hold_ticks;
    nl          = emergency;

    if (smp.cpu_valid) begin
      filt_next   = filter_primed ? filt_mix[12:2] : smp.cpu_temp;
      primed_next = 1'b1;
      if (filt_next > regs.cpu_alarm_three) nl = 2'd3;
      else if (filt_next > regs.cpu_alarm_two) nl = 2'd2;
      else if (filt_next > regs.cpu_alarm_one) nl = 2'd1;
      else if (filt_next < regs.cpu_clear) nl = 2'd0;
      else if (filt_next < regs.cpu_alarm_one && emergency >= 2'd2) nl = 2'd1;
      else if (filt_next < regs.cpu_alarm_two && emergency == 2'd3) nl = 2'd2;

      if (nl != emergency) begin
        // cap the base level by the rule of the level being left
        if (emergency == 2'd3 && base1 > LVL_MAX) base1 = LVL_MAX;
        if (emergency == 2'd2 && nl < 2'd2 && base1 > 5'sd8) base1 = 5'sd8;
        if (emergency == 2'd1 && nl == 2'd0 && base1 > 5'sd6) base1 = 5'sd6;
        hold1     = COOLDOWN_TICKS;
        emer_next = nl;
      end
    end

    if (batt_x >= $signed({2'b00, regs.battery_up_two})) delta = 3'sd2;
    else if (batt_x >= $signed({2'b00, regs.battery_up_one})) delta = 3'sd1;
    else if (batt_x <= $signed({2'b00, regs.battery_down_two})) delta = -3'sd2;
    else if (batt_x <= $signed({2'b00, regs.battery_down_one})) delta = -3'sd1;
    else delta = 3'sd0;

    stepped   = 6'(base1) + 6'(delta);
    base_next = base1;
    hold_next = hold1;
    if (hold1 != 4'd0) begin
      hold_next = hold1 - 4'd1;
    end else if (smp.battery_valid && delta != 3'sd0) begin
      base_next = clamp_level(stepped);
      hold_next = COOLDOWN_TICKS;
    end

    case (emer_next)
      2'd3:    fmin = 5'sd8;
      2'd2:    fmin = 5'sd6;
      2'd1:    fmin = 5'sd4;
      default: fmin = 5'sd0;
    endcase

    result.chosen_level = (fmin > base_next) ? fmin : base_next;
    result.alarm_level  = emer_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_level    <= '0;
      level_loaded  <= 1'b0;
      emergency     <= '0;
      cpu_filtered  <= 11'd250;
      filter_primed <= 1'b0;
      hold_ticks    <= '0;
    end else if (step) begin
      base_level    <= base_next;
      level_loaded  <= 1'b1;
      emergency     <= emer_next;
      cpu_filtered  <= filt_next;
      filter_primed <= primed_next;
      hold_ticks    <= hold_next;
    end
  end

endmodule

[src/thermal_fan_level_controller.sv]
// An accepted sample passes from the input register into the result register.
// Throughput: one transaction per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset (rst, synchronous): both registers empty, controller state cleared,
// configuration registers back to their defaults.
module thermal_fan_level_controller (
  input logic        clk,
  input logic        rst,
  tflc_in_if.sink    sample,
  tflc_out_if.source result,
  tflc_cfg_if.sink   cfg
);
  import tflc_pkg::*;

  cfg_t    regs;
  sample_t s1_data;
  logic    s1_valid;
  logic    res_valid;
  logic    advance;
  level_t  lvl;
  drive_t  drive;
  level_t  res_lvl;
  drive_t  res_drive;

  tflc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  tflc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .smp    (s1_data),
    .regs   (regs),
    .result (lvl)
  );

  assign advance      = s1_valid && (!res_valid || result.ready);
  assign sample.ready = !s1_valid || advance;
  assign drive        = level_drive(lvl.chosen_level);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_data <= '{sample.battery_temp, sample.battery_valid,
                   sample.cpu_temp, sample.cpu_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (advance) begin
      res_lvl   <= lvl;
      res_drive <= drive;
    end
  end

  assign result.valid          = res_valid;
  assign result.chosen_level   = res_lvl.chosen_level;
  assign result.alarm_level    = res_lvl.alarm_level;
  assign result.run_mode       = res_drive.run_mode;
  assign result.target_celsius = res_drive.target_celsius;
  assign result.fan_percent    = res_drive.fan_percent;
  assign result.cooler_percent = res_drive.cooler_percent;

endmodule
